### hdl/bottom_k_jaccard_check_assert.svh
// assertion macros for the bottom-k jaccard check block
`ifndef BOTTOM_K_JACCARD_CHECK_ASSERT_SVH
`define BOTTOM_K_JACCARD_CHECK_ASSERT_SVH

// property that must hold in the same cycle as its trigger
`define BKJC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bkjc assertion failed");

// property that must hold in the cycle after its trigger
`define BKJC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bkjc assertion failed");

`endif

### hdl/bkjc_pkg.sv
// shared constants for the bottom-k jaccard check block
package bkjc_pkg;

  localparam int SKETCH_DEPTH  = 256;
  localparam int ELEMENT_WIDTH = 32;
  localparam int ADDR_W        = $clog2(SKETCH_DEPTH);
  localparam int CNT_W         = $clog2(SKETCH_DEPTH + 1);
  localparam int MISS_W        = CNT_W + 1;
  localparam int THR_W         = 17;
  localparam int Q_FRAC        = 16;
  localparam int PROD_W        = THR_W + CNT_W;

  localparam logic [THR_W-1:0] Q16_ONE = THR_W'(1 << Q_FRAC);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(52429);

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [CNT_W-1:0]         cnt_t;

endpackage

### hdl/bottom_k_jaccard_check.sv
// bottom-k jaccard check top level: sketch stores, merge walk and result register
// loads are accepted back to back while no evaluation is running
// evaluate: take the command, form the required overlap, then walk in steps of
// a ram read and a compare, at most k steps, then finish and post the result;
// input stalls during evaluation and until the result register is free
// synchronous reset clears counts, overflow flag, sequencer state and sets threshold to 52429
`include "bottom_k_jaccard_check_assert.svh"

module bottom_k_jaccard_check
  import bkjc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       cmd,
  input  logic [31:0]      value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             similar,
  output logic [8:0]       overlap_count,
  output logic [8:0]       compared_size,
  output logic             overflow
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CALC  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_CMP   = 2'd3;

  logic [1:0]        state;
  logic [THR_W-1:0]  threshold;
  cnt_t              count_a;
  cnt_t              count_b;
  logic              overflow_seen;
  cnt_t              k;
  cnt_t              required;
  cnt_t              limit;
  cnt_t              ia;
  cnt_t              ib;
  cnt_t              overlap;
  logic [MISS_W-1:0] misses;
  logic              ovf_hold;

  logic              in_accept;
  logic              out_free;
  logic              full_a;
  logic              full_b;
  logic              we_a;
  logic              we_b;
  elem_t             rd_a;
  elem_t             rd_b;
  logic [THR_W-1:0]  thr_eff;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_up;
  logic              walk_done;
  logic              verdict;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign full_a    = (count_a == cnt_t'(SKETCH_DEPTH));
  assign full_b    = (count_b == cnt_t'(SKETCH_DEPTH));
  assign we_a      = in_accept && (cmd == CMD_LOAD_A) && !full_a;
  assign we_b      = in_accept && (cmd == CMD_LOAD_B) && !full_b;

  // sketch stores
  bkjc_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(SKETCH_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[ADDR_W-1:0]),
    .wdata (value[ELEMENT_WIDTH-1:0]),
    .raddr (ia[ADDR_W-1:0]),
    .rdata (rd_a)
  );

  bkjc_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(SKETCH_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[ADDR_W-1:0]),
    .wdata (value[ELEMENT_WIDTH-1:0]),
    .raddr (ib[ADDR_W-1:0]),
    .rdata (rd_b)
  );

  // required overlap: ceil(min(threshold, 1.0) * k)
  assign thr_eff = (threshold > Q16_ONE) ? Q16_ONE : threshold;
  assign prod    = PROD_W'(thr_eff) * PROD_W'(k);
  assign prod_up = prod + PROD_W'((1 << Q_FRAC) - 1);

  // walk stop conditions, checked before each step
  always_comb begin
    walk_done = 1'b1;
    verdict   = 1'b0;
    priority if (ia >= k || ib >= k) begin
      verdict = (overlap >= required);
    end else if (misses > MISS_W'(limit)) begin
      verdict = 1'b0;
    end else if (overlap >= required) begin
      verdict = 1'b1;
    end else begin
      walk_done = 1'b0;
    end
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // load counts and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
    end else if (in_accept) begin
      unique case (cmd)
        CMD_LOAD_A: begin
          if (full_a) overflow_seen <= 1'b1;
          else count_a <= count_a + cnt_t'(1);
        end
        CMD_LOAD_B: begin
          if (full_b) overflow_seen <= 1'b1;
          else count_b <= count_b + cnt_t'(1);
        end
        CMD_EVAL: begin
          count_a       <= '0;
          count_b       <= '0;
          overflow_seen <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // evaluation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept && cmd == CMD_EVAL) state <= ST_CALC;
        end
        ST_CALC: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!walk_done) state <= ST_CMP;
          else if (out_free) state <= ST_IDLE;
        end
        ST_CMP: begin
          state <= ST_CHECK;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept && cmd == CMD_EVAL) begin
      k        <= (count_a < count_b) ? count_a : count_b;
      ovf_hold <= overflow_seen;
      ia       <= '0;
      ib       <= '0;
      overlap  <= '0;
      misses   <= '0;
    end
    if (state == ST_CALC) begin
      required <= cnt_t'(prod_up >> Q_FRAC);
      limit    <= k - cnt_t'(prod_up >> Q_FRAC);
    end
    if (state == ST_CMP) begin
      priority if (rd_a == rd_b) begin
        overlap <= overlap + cnt_t'(1);
        ia      <= ia + cnt_t'(1);
        ib      <= ib + cnt_t'(1);
      end else if (rd_a < rd_b) begin
        ia     <= ia + cnt_t'(1);
        misses <= misses + MISS_W'(1);
      end else begin
        ib     <= ib + cnt_t'(1);
        misses <= misses + MISS_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_CHECK && walk_done && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK && walk_done && out_free) begin
      similar       <= verdict;
      overlap_count <= overlap;
      compared_size <= k;
      overflow      <= ovf_hold;
    end
  end

  // checks
  `BKJC_ASSERT_NOW(a_counts_in_range, clk, rst, 1'b1,
    count_a <= cnt_t'(SKETCH_DEPTH) && count_b <= cnt_t'(SKETCH_DEPTH))
  `BKJC_ASSERT_NOW(a_step_in_range, clk, rst, state == ST_CMP, ia < k && ib < k)
  `BKJC_ASSERT_NOW(a_overlap_le_size, clk, rst, out_valid, overlap_count <= compared_size)
  `BKJC_ASSERT_NEXT(a_result_posted, clk, rst,
    state == ST_CHECK && walk_done && out_free, out_valid && state == ST_IDLE)

endmodule

### hdl/bkjc_ram.sv
// generic single-write, single-read ram with registered read data
module bkjc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
